// ----- rtl/stn_pkg.sv -----
// Shared types, constants and helper functions of the source text normalizer.
package stn_pkg;

   // Saturation limits of the indentation and space-run counters.
   localparam int unsigned INDENT_MAX    = 48;
   localparam int unsigned SPACE_RUN_MAX = 48;
   // Most results one item may cause; later bytes are dropped.
   localparam int unsigned MAX_RESULTS   = 50;
   localparam int unsigned CNT_W         = $clog2(MAX_RESULTS);

   // Held bytes of a possible sintNN keyword.
   localparam int unsigned HELD_MAX      = 6;
   localparam int unsigned HELD_W        = 8 * HELD_MAX;

   // Command queue between front and back.
   localparam int unsigned QUEUE_DEPTH   = 4;
   localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_1   = 8'h31;
   localparam logic [7:0] CH_2   = 8'h32;
   localparam logic [7:0] CH_3   = 8'h33;
   localparam logic [7:0] CH_4   = 8'h34;
   localparam logic [7:0] CH_6   = 8'h36;
   localparam logic [7:0] CH_8   = 8'h38;
   localparam logic [7:0] CH_I   = 8'h69;
   localparam logic [7:0] CH_N   = 8'h6E;
   localparam logic [7:0] CH_S   = 8'h73;
   localparam logic [7:0] CH_T   = 8'h74;

   // One command: spaces, then a slice of held bytes, then a tail byte or bare marker.
   typedef struct packed {
      logic [6:0]        nsp;
      logic [HELD_W-1:0] held;
      logic [2:0]        hstart;
      logic [2:0]        hcnt;
      logic              has_byte;
      logic [7:0]        out_byte;
      logic              bare;
      logic              is_end;
      logic              overflow;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic word_byte(input logic [7:0] c);
      return (c == 8'h5F) || (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [7:0] held_at(input logic [HELD_W-1:0] held,
                                          input logic [2:0] k);
      logic [7:0] b;
      b = 8'h00;
      for (int i = 0; i < HELD_MAX; i++) begin
         if (k == 3'(i)) begin
            b = held[8*i +: 8];
         end
      end
      return b;
   endfunction

endpackage

// ----- rtl/stn_front.sv -----
// Front part: accepts items, tracks line state and issues output commands.
module stn_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             action,
   input  logic [7:0]       data_byte,
   output logic             push,
   output stn_pkg::cmd_type push_cmd
);
   import stn_pkg::*;

   logic                in_indent_ff, in_indent_in;
   logic [5:0]          indent_ff, indent_in;
   logic [5:0]          space_run_ff, space_run_in;
   logic [HELD_W-1:0]   held_ff, held_in;
   logic [2:0]          held_len_ff, held_len_in;
   logic                prev_word_ff, prev_word_in;
   logic                after_cr_ff, after_cr_in;
   logic                last_lf_ff, last_lf_in;
   logic                ovf_ff, ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_indent_ff <= 1'b1;
         indent_ff    <= '0;
         space_run_ff <= '0;
         held_ff      <= '0;
         held_len_ff  <= '0;
         prev_word_ff <= 1'b0;
         after_cr_ff  <= 1'b0;
         last_lf_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         in_indent_ff <= in_indent_in;
         indent_ff    <= indent_in;
         space_run_ff <= space_run_in;
         held_ff      <= held_in;
         held_len_ff  <= held_len_in;
         prev_word_ff <= prev_word_in;
         after_cr_ff  <= after_cr_in;
         last_lf_ff   <= last_lf_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_comb begin
      logic [6:0] ind_sum;
      logic [5:0] ind_round;
      logic       word_c;
      logic       prev_eff;
      logic       complete;
      logic       grows;
      logic       anything;
      cmd_type    cmd;

      in_indent_in = in_indent_ff;
      indent_in    = indent_ff;
      space_run_in = space_run_ff;
      held_in      = held_ff;
      held_len_in  = held_len_ff;
      prev_word_in = prev_word_ff;
      after_cr_in  = after_cr_ff;
      last_lf_in   = last_lf_ff;
      ovf_in       = ovf_ff;
      cmd          = '0;
      ind_sum      = '0;
      anything     = 1'b0;
      prev_eff     = in_indent_ff ? 1'b0 : prev_word_ff;
      word_c       = word_byte(data_byte);
      ind_round    = indent_ff + {5'd0, indent_ff[0]};
      complete     = (held_len_ff == 3'd5 && held_ff[39:32] == CH_8) ||
                     (held_len_ff == 3'(HELD_MAX));
      case (held_len_ff)
         3'd1:    grows = (data_byte == CH_I);
         3'd2:    grows = (data_byte == CH_N);
         3'd3:    grows = (data_byte == CH_T);
         3'd4:    grows = (data_byte == CH_8) || (data_byte == CH_1) ||
                          (data_byte == CH_3) || (data_byte == CH_6);
         3'd5:    grows = (held_ff[39:32] == CH_1 && data_byte == CH_6) ||
                          (held_ff[39:32] == CH_3 && data_byte == CH_2) ||
                          (held_ff[39:32] == CH_6 && data_byte == CH_4);
         default: grows = 1'b0;
      endcase

      if (accept) begin
         if (action) begin
            // End of stream: flush, add a closing LF if needed, back to reset state.
            if (in_indent_ff) begin
               cmd.nsp  = {1'b0, ind_round};
               anything = (ind_round != 6'd0);
            end else if (held_len_ff != 3'd0) begin
               cmd.held   = held_ff;
               cmd.hstart = {2'b00, complete};
               cmd.hcnt   = held_len_ff - {2'b00, complete};
               anything   = 1'b1;
            end
            cmd.has_byte = !(last_lf_ff && !anything);
            cmd.out_byte = CH_LF;
            cmd.bare     = !cmd.has_byte;
            cmd.is_end   = 1'b1;
            cmd.overflow = ovf_ff;
            in_indent_in = 1'b1;
            indent_in    = '0;
            space_run_in = '0;
            held_in      = '0;
            held_len_in  = '0;
            prev_word_in = 1'b0;
            after_cr_in  = 1'b0;
            last_lf_in   = 1'b0;
            ovf_in       = 1'b0;
         end else if (after_cr_ff && data_byte == CH_LF) begin
            after_cr_in = 1'b0;
         end else begin
            after_cr_in = 1'b0;
            if (data_byte == CH_CR || data_byte == CH_LF) begin
               if (in_indent_ff) begin
                  cmd.nsp = {1'b0, ind_round};
               end else if (held_len_ff != 3'd0) begin
                  cmd.held   = held_ff;
                  cmd.hstart = {2'b00, complete};
                  cmd.hcnt   = held_len_ff - {2'b00, complete};
               end
               cmd.has_byte = 1'b1;
               cmd.out_byte = CH_LF;
               in_indent_in = 1'b1;
               indent_in    = '0;
               space_run_in = '0;
               held_in      = '0;
               held_len_in  = '0;
               prev_word_in = 1'b0;
               after_cr_in  = (data_byte == CH_CR);
            end else if (in_indent_ff && (data_byte == CH_SP || data_byte == CH_TAB)) begin
               ind_sum = {1'b0, indent_ff} + ((data_byte == CH_SP) ? 7'd1 : 7'd2);
               if (ind_sum > 7'(INDENT_MAX)) begin
                  indent_in = 6'(INDENT_MAX);
                  ovf_in    = 1'b1;
               end else begin
                  indent_in = ind_sum[5:0];
               end
            end else begin
               if (in_indent_ff) begin
                  cmd.nsp      = {1'b0, ind_round};
                  in_indent_in = 1'b0;
                  indent_in    = '0;
               end
               if (data_byte == CH_SP) begin
                  if (held_len_ff != 3'd0) begin
                     cmd.held   = held_ff;
                     cmd.hstart = {2'b00, complete};
                     cmd.hcnt   = held_len_ff - {2'b00, complete};
                  end
                  held_in     = '0;
                  held_len_in = '0;
                  if (space_run_ff >= 6'(SPACE_RUN_MAX)) begin
                     ovf_in = 1'b1;
                  end else begin
                     space_run_in = space_run_ff + 6'd1;
                  end
                  prev_word_in = 1'b0;
               end else begin
                  cmd.nsp      = cmd.nsp + {1'b0, space_run_ff};
                  space_run_in = '0;
                  if (held_len_ff != 3'd0) begin
                     if (grows) begin
                        for (int k = 0; k < HELD_MAX; k++) begin
                           if (held_len_ff == 3'(k)) begin
                              held_in[8*k +: 8] = data_byte;
                           end
                        end
                        held_len_in = held_len_ff + 3'd1;
                     end else begin
                        cmd.held     = held_ff;
                        cmd.hstart   = {2'b00, complete && !word_c};
                        cmd.hcnt     = held_len_ff - {2'b00, complete && !word_c};
                        cmd.has_byte = 1'b1;
                        cmd.out_byte = data_byte;
                        held_in      = '0;
                        held_len_in  = '0;
                        prev_word_in = word_c;
                     end
                  end else if (data_byte == CH_S && !prev_eff) begin
                     held_in      = {{(HELD_W-8){1'b0}}, data_byte};
                     held_len_in  = 3'd1;
                     prev_word_in = 1'b1;
                  end else begin
                     cmd.has_byte = 1'b1;
                     cmd.out_byte = data_byte;
                     prev_word_in = word_c;
                  end
               end
            end
            cmd.overflow = ovf_in;
            // Track whether the last emitted byte was an LF.
            if (cmd.nsp != 7'd0 || cmd.hcnt != 3'd0 || cmd.has_byte) begin
               last_lf_in = cmd.has_byte && (cmd.out_byte == CH_LF);
            end
         end
      end

      push     = accept && (cmd.nsp != 7'd0 || cmd.hcnt != 3'd0 || cmd.has_byte || cmd.bare);
      push_cmd = cmd;
   end

endmodule

// ----- rtl/stn_queue.sv -----
// Short command queue between the front and back parts.
module stn_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stn_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output stn_pkg::cmd_type      head,
   output stn_pkg::q_status_type status
);
   import stn_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue read while empty");

endmodule

// ----- rtl/stn_back.sv -----
// Back part: expands queued commands into result items, one per cycle unless stalled.
module stn_back (
   input  logic                  clock,
   input  logic                  reset,
   input  stn_pkg::cmd_type      head,
   input  stn_pkg::q_status_type status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_byte_valid,
   output logic                  rsp_last,
   output logic                  rsp_overflow
);
   import stn_pkg::*;

   logic [6:0]       sp_ff, sp_in;
   logic [2:0]       hk_ff, hk_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             bvalid_ff, bvalid_in;
   logic             last_ff, last_in;
   logic             ovf_ff, ovf_in;

   logic             fire;
   logic             fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= '0;
         hk_ff    <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sp_ff    <= sp_in;
         hk_ff    <= hk_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      last_ff   <= last_in;
      ovf_ff    <= ovf_in;
   end

   always_comb begin
      logic sp_phase;
      logic held_phase;
      logic tail;
      logic out_free;
      logic [7:0] elem;

      out_free   = !valid_ff || !rsp_stall;
      fire       = !status.empty && out_free;
      sp_phase   = (sp_ff < head.nsp);
      held_phase = !sp_phase && (hk_ff < head.hcnt);
      tail       = head.has_byte || head.bare;
      if (sp_phase) begin
         elem = CH_SP;
      end else if (held_phase) begin
         elem = held_at(head.held, head.hstart + hk_ff);
      end else begin
         elem = head.out_byte;
      end
      // Final element of the command, or result limit reached.
      fin = (!sp_phase && !held_phase) ||
            (sp_phase && (sp_ff + 7'd1 == head.nsp) && head.hcnt == 3'd0 && !tail) ||
            (held_phase && (hk_ff + 3'd1 == head.hcnt) && !tail) ||
            (cnt_ff == CNT_W'(MAX_RESULTS - 1));

      sp_in     = sp_ff;
      hk_in     = hk_ff;
      cnt_in    = cnt_ff;
      valid_in  = out_free ? fire : valid_ff;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      last_in   = last_ff;
      ovf_in    = ovf_ff;
      pop       = 1'b0;
      if (fire) begin
         byte_in   = (!sp_phase && !held_phase && head.bare) ? 8'h00 : elem;
         bvalid_in = !(!sp_phase && !held_phase && head.bare);
         last_in   = fin && head.is_end;
         ovf_in    = head.overflow;
         if (fin) begin
            pop    = 1'b1;
            sp_in  = '0;
            hk_in  = '0;
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (sp_phase) begin
               sp_in = sp_ff + 7'd1;
            end else begin
               hk_in = hk_ff + 3'd1;
            end
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_last       = last_ff;
   assign rsp_overflow   = ovf_ff;

   a_bare_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !bvalid_ff |-> last_ff)
      else $error("bare result without last");

   a_progress_clears: assert property (@(posedge clock) disable iff (reset)
      fire && fin |=> sp_ff == 7'd0 && hk_ff == 3'd0 && cnt_ff == '0)
      else $error("command progress not cleared after final element");

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      !status.empty |-> sp_ff <= head.nsp)
      else $error("space counter ran past command");

endmodule

// ----- rtl/source_text_normalizer.sv -----
// Top level of the streaming source text normalizer.
// Usage:
//  - req channel: one item per handshake (req_valid high, req_stall low). req_action 0
//    carries req_data_byte; req_action 1 ends the stream, flushes held text and adds a
//    closing LF when the output is empty or does not end in LF.
//  - rsp channel: one output byte per item. rsp_byte_valid is 0 only on the bare end
//    marker; rsp_last marks the final item of a stream; rsp_overflow reports that an
//    indentation or space-run counter saturated during the stream.
//  - Throughput: the front takes one input item per cycle while the command queue
//    (four entries) has room. The back emits one result per cycle while rsp_stall
//    is low; an item that causes more than one result holds the back until its last
//    result is out (indent and space bursts up to 48); req_stall rises when the queue
//    fills behind it. With the queue empty, an accepted item's command is first
//    written into the queue, then its first result is loaded into the output register.
//  - Reset (synchronous, active high) returns the block to line start with nothing
//    held and empties the queue; end of stream also resets the front's line state.
//  - A stalled receiver freezes the output register; the queue keeps taking items
//    until it fills.
module source_text_normalizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic       rsp_overflow
);
   import stn_pkg::*;

   logic         accept;
   logic         push;
   logic         pop;
   cmd_type      push_cmd;
   cmd_type      head;
   q_status_type status;

   // Hold off the source while the command queue is full.
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   // Front: classify each byte, update line state, issue commands as needed.
   stn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .data_byte (req_data_byte),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // Queue: decouple classification from byte emission.
   stn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (status)
   );

   // Back: expand commands into output items through the output register.
   stn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .status         (status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_overflow   (rsp_overflow)
   );

endmodule
